// ===== design/card_frame_access_matcher_unit_macros.svh =====
// Assertion macros shared by the card frame access matcher modules.
// No dependencies; taken in by `include where a module checks itself.
`ifndef CARD_FRAME_ACCESS_MATCHER_UNIT_MACROS_SVH
`define CARD_FRAME_ACCESS_MATCHER_UNIT_MACROS_SVH

// Antecedent and consequent in the same cycle
`define CFAM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent in the cycle after the antecedent
`define CFAM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/cfam_pkg.sv =====
// Shared types and constants of the card frame access matcher.
// No dependencies; used by the controller, datapath and top level.
package cfam_pkg;

    localparam int CMD_W       = 2;
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = 9;
    localparam int ID_W        = 40;
    localparam int ENTRY_W     = ID_W + 1;
    localparam int CNT_W       = 4;
    localparam int FB_W        = 5;
    localparam int OUTC_W      = 3;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 56;

    // Request kinds on the input tuser
    localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EXIT  = 2'd2;

    // Outcome codes on the output tuser
    localparam logic [OUTC_W-1:0] OUT_GRANT    = 3'd0;
    localparam logic [OUTC_W-1:0] OUT_EXIT     = 3'd1;
    localparam logic [OUTC_W-1:0] OUT_ENROLLED = 3'd2;
    localparam logic [OUTC_W-1:0] OUT_DENIED   = 3'd3;
    localparam logic [OUTC_W-1:0] OUT_IGNORED  = 3'd4;
    localparam logic [OUTC_W-1:0] OUT_FULL     = 3'd5;

    localparam logic [BYTE_W-1:0] BYTE_START = 8'd2;
    localparam logic [BYTE_W-1:0] BYTE_END_A = 8'd3;
    localparam logic [BYTE_W-1:0] BYTE_END_B = 8'd255;
    localparam logic [BYTE_W-1:0] CHAR_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_9     = 8'h39;

    localparam logic [CNT_W-1:0]  ID_DIGITS     = 4'd10;
    localparam logic [CNT_W-1:0]  DIGIT_SAT     = 4'd11;
    localparam logic [FB_W-1:0]   FB_MAX        = 5'd31;
    localparam logic [FB_W-1:0]   MAX_FRAME_RST = 5'd25;

    typedef struct packed {
        logic              load_item;
        logic              byte_step;
        logic              tbl_write;
        logic              scan_start;
        logic              scan_step;
        logic              clr_step;
        logic              enroll_wr;
        logic              res_set;
        logic [OUTC_W-1:0] res_code;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] item_cmd;
        logic             frame_end;
        logic             full_len;
        logic             enroll;
        logic             scan_done;
        logic             hit;
        logic             free_found;
        logic             clr_done;
        logic             out_free;
    } t_dp_stat;

endpackage

// ===== design/cfam_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cfam_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/cfam_datapath.sv =====
// Datapath: request hold, frame parser, ID table with scan unit, result register.
// Depends on cfam_pkg, cfam_ram and the assertion macro header.
`include "card_frame_access_matcher_unit_macros.svh"

module cfam_datapath #(
    parameter int TABLE_DEPTH = 512
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cfam_pkg::FB_W-1:0]      i_cfg_wdata,
    input  logic [cfam_pkg::CMD_W-1:0]     i_cmd,
    input  logic [cfam_pkg::BYTE_W-1:0]    i_rx_byte,
    input  logic                           i_enroll,
    input  logic [cfam_pkg::IDX_W-1:0]     i_entry_index,
    input  logic [cfam_pkg::ID_W-1:0]      i_entry_id,
    input  logic                           i_entry_valid,
    input  logic                           i_out_ready,
    input  cfam_pkg::t_dp_cmd              i_dp_cmd,
    output cfam_pkg::t_dp_stat             o_dp_stat,
    output logic                           o_out_valid,
    output logic [cfam_pkg::OUTC_W-1:0]    o_outcome,
    output logic [cfam_pkg::ID_W-1:0]      o_card_id,
    output logic [cfam_pkg::CNT_W-1:0]     o_digit_count,
    output logic [cfam_pkg::IDX_W-1:0]     o_match_index
);

    localparam int         AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [AW:0] DEPTH_C = (AW + 1)'(TABLE_DEPTH);

    // held request
    logic [cfam_pkg::CMD_W-1:0]  r_in_cmd;
    logic [cfam_pkg::BYTE_W-1:0] r_in_byte;
    logic                        r_in_enroll;
    logic [cfam_pkg::IDX_W-1:0]  r_in_idx;
    logic [cfam_pkg::ID_W-1:0]   r_in_id;
    logic                        r_in_valid;

    // frame state
    logic                        r_in_frame;
    logic                        r_id_started;
    logic [cfam_pkg::FB_W-1:0]   r_fb_cnt;
    logic [cfam_pkg::CNT_W-1:0]  r_dig_cnt;
    logic [cfam_pkg::ID_W-1:0]   r_id_shift;
    logic [cfam_pkg::FB_W-1:0]   r_max_frame;
    logic                        r_ended;
    logic [cfam_pkg::ID_W-1:0]   r_key;
    logic [cfam_pkg::CNT_W-1:0]  r_key_cnt;

    // scan unit
    logic [AW:0]                 r_scan_cnt;
    logic                        r_rd_vld;
    logic [AW-1:0]               r_rd_addr;
    logic                        r_hit;
    logic [AW-1:0]               r_hit_idx;
    logic                        r_free_found;
    logic [AW-1:0]               r_free_idx;

    // result register
    logic                        r_out_vld;
    logic [cfam_pkg::OUTC_W-1:0] r_out_code;
    logic [cfam_pkg::ID_W-1:0]   r_out_id;
    logic [cfam_pkg::CNT_W-1:0]  r_out_cnt;
    logic [cfam_pkg::IDX_W-1:0]  r_out_idx;

    // next values of the parser
    logic                        n_started;
    logic [cfam_pkg::FB_W-1:0]   n_fb;
    logic [cfam_pkg::ID_W-1:0]   n_shift;
    logic [cfam_pkg::CNT_W-1:0]  n_dig;
    logic                        n_end;
    logic [cfam_pkg::FB_W-1:0]   base_fb;
    logic [cfam_pkg::ID_W-1:0]   base_shift;
    logic [cfam_pkg::CNT_W-1:0]  base_dig;
    logic                        is_term;
    logic                        take_digit;

    logic                        rd_en;
    logic                        idx_in_range;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [cfam_pkg::ENTRY_W-1:0] ram_wdata;
    logic [cfam_pkg::ENTRY_W-1:0] ram_rdata;
    logic                        out_free;

    // frame parser: a byte outside a frame opens a fresh one
    always_comb begin
        base_fb    = r_in_frame ? r_fb_cnt   : '0;
        base_shift = r_in_frame ? r_id_shift : '0;
        base_dig   = r_in_frame ? r_dig_cnt  : '0;
        n_fb       = (base_fb < cfam_pkg::FB_MAX) ? base_fb + 1'b1 : base_fb;
        n_started  = (r_in_frame & r_id_started) | (r_in_byte == cfam_pkg::BYTE_START);
        is_term    = (r_in_byte == cfam_pkg::BYTE_END_A) || (r_in_byte == cfam_pkg::BYTE_END_B);
        take_digit = !is_term && n_started &&
                     (r_in_byte >= cfam_pkg::CHAR_0) && (r_in_byte <= cfam_pkg::CHAR_9);
        n_shift    = take_digit ? {base_shift[cfam_pkg::ID_W-5:0], r_in_byte[3:0]}
                                : base_shift;
        n_dig      = (take_digit && (base_dig < cfam_pkg::DIGIT_SAT)) ? base_dig + 1'b1
                                                                       : base_dig;
        n_end      = is_term || (n_fb >= r_max_frame);
    end

    assign idx_in_range = (int'(r_in_idx) < TABLE_DEPTH);
    assign rd_en        = i_dp_cmd.scan_step && (r_scan_cnt < DEPTH_C) && !r_hit;
    assign out_free     = !r_out_vld || i_out_ready;

    // table write port: clearing pass, preload, enrolment
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_scan_cnt[AW-1:0];
        ram_wdata = '0;
        if (i_dp_cmd.clr_step) begin
            ram_we = 1'b1;
        end else if (i_dp_cmd.tbl_write) begin
            ram_we    = idx_in_range;
            ram_waddr = AW'(r_in_idx);
            ram_wdata = {r_in_valid, r_in_id};
        end else if (i_dp_cmd.enroll_wr) begin
            ram_we    = 1'b1;
            ram_waddr = r_free_idx;
            ram_wdata = {1'b1, r_key};
        end
    end

    cfam_ram #(
        .WIDTH (cfam_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (rd_en),
        .i_raddr (r_scan_cnt[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_id_started <= 1'b0;
            r_fb_cnt     <= '0;
            r_dig_cnt    <= '0;
            r_id_shift   <= '0;
            r_max_frame  <= cfam_pkg::MAX_FRAME_RST;
            r_ended      <= 1'b0;
            r_scan_cnt   <= '0;
            r_rd_vld     <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_frame <= i_cfg_wdata;
            end
            if (i_dp_cmd.byte_step) begin
                r_ended <= n_end;
                if (n_end) begin
                    r_in_frame   <= 1'b0;
                    r_id_started <= 1'b0;
                    r_fb_cnt     <= '0;
                    r_dig_cnt    <= '0;
                    r_id_shift   <= '0;
                end else begin
                    r_in_frame   <= 1'b1;
                    r_id_started <= n_started;
                    r_fb_cnt     <= n_fb;
                    r_dig_cnt    <= n_dig;
                    r_id_shift   <= n_shift;
                end
            end
            if (i_dp_cmd.scan_start) begin
                r_scan_cnt   <= '0;
                r_rd_vld     <= 1'b0;
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
            end else begin
                if (i_dp_cmd.clr_step || rd_en) begin
                    r_scan_cnt <= r_scan_cnt + 1'b1;
                end
                r_rd_vld <= rd_en;
                if (r_rd_vld) begin
                    // lowest valid match wins; remember the lowest free entry
                    if (ram_rdata[cfam_pkg::ID_W] && (ram_rdata[cfam_pkg::ID_W-1:0] == r_key)
                        && !r_hit) begin
                        r_hit <= 1'b1;
                    end
                    if (!ram_rdata[cfam_pkg::ID_W] && !r_free_found) begin
                        r_free_found <= 1'b1;
                    end
                end
            end
            if (i_dp_cmd.res_set) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load_item) begin
            r_in_cmd    <= i_cmd;
            r_in_byte   <= i_rx_byte;
            r_in_enroll <= i_enroll;
            r_in_idx    <= i_entry_index;
            r_in_id     <= i_entry_id;
            r_in_valid  <= i_entry_valid;
        end
        if (i_dp_cmd.byte_step && n_end) begin
            r_key     <= n_shift;
            r_key_cnt <= n_dig;
        end
        r_rd_addr <= r_scan_cnt[AW-1:0];
        if (r_rd_vld && !i_dp_cmd.scan_start) begin
            if (ram_rdata[cfam_pkg::ID_W] && (ram_rdata[cfam_pkg::ID_W-1:0] == r_key)
                && !r_hit) begin
                r_hit_idx <= r_rd_addr;
            end
            if (!ram_rdata[cfam_pkg::ID_W] && !r_free_found) begin
                r_free_idx <= r_rd_addr;
            end
        end
        if (i_dp_cmd.res_set) begin
            r_out_code <= i_dp_cmd.res_code;
            r_out_id   <= (i_dp_cmd.res_code == cfam_pkg::OUT_EXIT) ? '0 : r_key;
            r_out_cnt  <= (i_dp_cmd.res_code == cfam_pkg::OUT_EXIT) ? '0 : r_key_cnt;
            case (i_dp_cmd.res_code)
                cfam_pkg::OUT_GRANT:    r_out_idx <= cfam_pkg::IDX_W'(r_hit_idx);
                cfam_pkg::OUT_ENROLLED: r_out_idx <= cfam_pkg::IDX_W'(r_free_idx);
                default:                r_out_idx <= '0;
            endcase
        end
    end

    always_comb begin
        o_dp_stat.item_cmd   = r_in_cmd;
        o_dp_stat.frame_end  = r_ended;
        o_dp_stat.full_len   = (r_key_cnt == cfam_pkg::ID_DIGITS);
        o_dp_stat.enroll     = r_in_enroll;
        o_dp_stat.scan_done  = r_hit || ((r_scan_cnt == DEPTH_C) && !r_rd_vld);
        o_dp_stat.hit        = r_hit;
        o_dp_stat.free_found = r_free_found;
        o_dp_stat.clr_done   = (r_scan_cnt == DEPTH_C);
        o_dp_stat.out_free   = out_free;
    end

    assign o_out_valid   = r_out_vld;
    assign o_outcome     = r_out_code;
    assign o_card_id     = r_out_id;
    assign o_digit_count = r_out_cnt;
    assign o_match_index = r_out_idx;

    `CFAM_ASSERT_NOW(a_enroll_on_free, i_clk, i_rst_n, i_dp_cmd.enroll_wr, r_free_found && !r_hit, "enrolment without a free entry or after a match")
    `CFAM_ASSERT_NOW(a_idx_zero, i_clk, i_rst_n, r_out_vld && (r_out_code != cfam_pkg::OUT_GRANT) && (r_out_code != cfam_pkg::OUT_ENROLLED), r_out_idx == '0, "match index set on an outcome without an entry")
    `CFAM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, r_out_vld && !i_out_ready && !i_dp_cmd.res_set, r_out_vld && $stable(r_out_code), "pending result lost or changed")

endmodule

// ===== design/cfam_ctrl.sv =====
// Controller state machine: request sequencing, table scan control, result issue.
// Depends on cfam_pkg and the assertion macro header.
`include "card_frame_access_matcher_unit_macros.svh"

module cfam_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  cfam_pkg::t_dp_stat  i_dp_stat,
    output cfam_pkg::t_dp_cmd   o_dp_cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_ENDCHK,
        ST_SCAN,
        ST_DECIDE,
        ST_RESULT
    } t_state;

    t_state                      r_state;
    logic [cfam_pkg::OUTC_W-1:0] r_code;

    always_comb begin
        o_dp_cmd          = '0;
        o_dp_cmd.res_code = r_code;
        case (r_state)
            ST_CLEAR:  o_dp_cmd.clr_step  = !i_dp_stat.clr_done;
            ST_IDLE:   o_dp_cmd.load_item = i_in_valid;
            ST_EXEC: begin
                o_dp_cmd.byte_step = (i_dp_stat.item_cmd == cfam_pkg::CMD_BYTE);
                o_dp_cmd.tbl_write = (i_dp_stat.item_cmd == cfam_pkg::CMD_WRITE);
            end
            ST_ENDCHK: o_dp_cmd.scan_start = i_dp_stat.frame_end && i_dp_stat.full_len;
            ST_SCAN:   o_dp_cmd.scan_step  = 1'b1;
            ST_DECIDE: o_dp_cmd.enroll_wr  = !i_dp_stat.hit && i_dp_stat.enroll &&
                                             i_dp_stat.free_found;
            ST_RESULT: o_dp_cmd.res_set    = i_dp_stat.out_free;
            default:   o_dp_cmd            = '0;
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_code  <= cfam_pkg::OUT_GRANT;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    if (i_dp_stat.clr_done) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    case (i_dp_stat.item_cmd)
                        cfam_pkg::CMD_BYTE: r_state <= ST_ENDCHK;
                        cfam_pkg::CMD_EXIT: begin
                            r_code  <= cfam_pkg::OUT_EXIT;
                            r_state <= ST_RESULT;
                        end
                        default:            r_state <= ST_IDLE;
                    endcase
                end
                ST_ENDCHK: begin
                    if (!i_dp_stat.frame_end) begin
                        r_state <= ST_IDLE;
                    end else if (!i_dp_stat.full_len) begin
                        r_code  <= cfam_pkg::OUT_IGNORED;
                        r_state <= ST_RESULT;
                    end else begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (i_dp_stat.scan_done) begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (i_dp_stat.hit) begin
                        r_code <= cfam_pkg::OUT_GRANT;
                    end else if (!i_dp_stat.enroll) begin
                        r_code <= cfam_pkg::OUT_DENIED;
                    end else if (i_dp_stat.free_found) begin
                        r_code <= cfam_pkg::OUT_ENROLLED;
                    end else begin
                        r_code <= cfam_pkg::OUT_FULL;
                    end
                    r_state <= ST_RESULT;
                end
                ST_RESULT: begin
                    // hold until the result register has room
                    if (i_dp_stat.out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `CFAM_ASSERT_NXT(a_load_exec, i_clk, i_rst_n, o_dp_cmd.load_item, r_state == ST_EXEC, "accepted request not executed")
    `CFAM_ASSERT_NOW(a_decide_after_scan, i_clk, i_rst_n, r_state == ST_DECIDE, $past(i_dp_stat.scan_done), "decision taken before the scan finished")
    `CFAM_ASSERT_NOW(a_no_accept_busy, i_clk, i_rst_n, o_in_ready, !o_dp_cmd.scan_step && !o_dp_cmd.clr_step, "request taken while the table is busy")

endmodule

// ===== design/card_frame_access_matcher_unit.sv =====
// Top level of the card frame access matcher: stream ports and config register.
// Depends on cfam_pkg, cfam_ctrl, cfam_datapath (and through it cfam_ram).
//
//  Channel  Dir  Handshake                      Content
//  s_axis   in   s_axis_tvalid/s_axis_tready    tuser: command; tdata: request fields
//  m_axis   out  m_axis_tvalid/m_axis_tready    tuser: outcome; tdata: result fields
//  cfg      in   i_cfg_we                       i_cfg_wdata: max_frame_bytes
//
// A received byte runs through the execute and end-check states, and the result state too when
// it closes a frame of another length than ten digits; a table write finishes in the execute state.
// An exit request issues a result. A frame end with ten digits walks the ID table, one
// entry a cycle through the single RAM read port, and stops early on a match. After
// reset a clearing pass empties the table; no request is taken meanwhile. A stalled
// result waits in the output register; the next request that brings a result holds in
// the result state until that register frees.
module card_frame_access_matcher_unit #(
    parameter int TABLE_DEPTH = 512
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [cfam_pkg::FB_W-1:0]            i_cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // rx_byte[7:0], enroll_button[8], entry_index[17:9], entry_id[57:18],
    // entry_valid[58], zero fill above
    input  logic [cfam_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // command[1:0]
    input  logic [cfam_pkg::CMD_W-1:0]           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // card_id[39:0], id_digit_count[43:40], match_index[52:44], zero fill above
    output logic [cfam_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // outcome[2:0]
    output logic [cfam_pkg::OUTC_W-1:0]          m_axis_tuser
);

    cfam_pkg::t_dp_cmd           dp_cmd;
    cfam_pkg::t_dp_stat          dp_stat;
    logic [cfam_pkg::ID_W-1:0]   card_id;
    logic [cfam_pkg::CNT_W-1:0]  digit_count;
    logic [cfam_pkg::IDX_W-1:0]  match_index;

    cfam_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_dp_stat  (dp_stat),
        .o_dp_cmd   (dp_cmd)
    );

    cfam_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd         (s_axis_tuser),
        .i_rx_byte     (s_axis_tdata[7:0]),
        .i_enroll      (s_axis_tdata[8]),
        .i_entry_index (s_axis_tdata[17:9]),
        .i_entry_id    (s_axis_tdata[57:18]),
        .i_entry_valid (s_axis_tdata[58]),
        .i_out_ready   (m_axis_tready),
        .i_dp_cmd      (dp_cmd),
        .o_dp_stat     (dp_stat),
        .o_out_valid   (m_axis_tvalid),
        .o_outcome     (m_axis_tuser),
        .o_card_id     (card_id),
        .o_digit_count (digit_count),
        .o_match_index (match_index)
    );

    assign m_axis_tdata = {3'b000, match_index, digit_count, card_id};

endmodule
